// ===== src/lmfs_pkg.sv =====
// Shared types and constants for the limp-mode fault supervisor.
// Used by lmfs_core, limp_mode_fault_supervisor and the port checker.
`default_nettype none

package lmfs_pkg;

	// Configuration register indexes, in the order of the register map.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_FUEL_CUT_RPM     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COOLANT_LIMIT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BATTERY_MIN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BATTERY_MAX      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LIMP_MS      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_HOLD_MS = 3'd6;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned TIME_W     = 32;

	// Register values after reset.
	localparam logic [15:0]        RST_FUEL_CUT_RPM     = 16'd7000;
	localparam logic [15:0]        RST_MAX_RPM          = 16'd7500;
	localparam logic signed [15:0] RST_COOLANT_LIMIT    = 16'sd120;
	localparam logic [15:0]        RST_BATTERY_MIN      = 16'd90;
	localparam logic [15:0]        RST_BATTERY_MAX      = 16'd160;
	localparam logic [15:0]        RST_MIN_LIMP_MS      = 16'd5000;
	localparam logic [15:0]        RST_RECOVERY_HOLD_MS = 16'd2000;

	typedef struct packed {
		logic [15:0]        fuel_cut_rpm;
		logic [15:0]        max_rpm;
		logic signed [15:0] coolant_limit;
		logic [15:0]        battery_min;
		logic [15:0]        battery_max;
		logic [15:0]        min_limp_ms;
		logic [15:0]        recovery_hold_ms;
	} lmfs_cfg_t;

	// Declared last field first, so now_ms lands in the lowest bits.
	typedef struct packed {
		logic               recover_request;
		logic               conditions_safe;
		logic [15:0]        battery_decivolts;
		logic signed [15:0] coolant_temp;
		logic [15:0]        engine_rpm;
		logic [TIME_W-1:0]  now_ms;
	} lmfs_sample_t;

	// Declared last field first, so limp_active lands in bit 0.
	typedef struct packed {
		logic limp_exited;
		logic recovery_armed;
		logic limp_entered;
		logic battery_fault;
		logic overheat_fault;
		logic over_rev_fault;
		logic limp_active;
	} lmfs_result_t;

	typedef struct packed {
		logic              limp_on;
		logic [TIME_W-1:0] limp_start_ms;
		logic              hold_armed;
		logic [TIME_W-1:0] hold_start_ms;
	} lmfs_state_t;

	localparam int unsigned SAMPLE_W    = $bits(lmfs_sample_t);
	localparam int unsigned RESULT_W    = $bits(lmfs_result_t);
	localparam int unsigned IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
	localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== src/lmfs_core.sv =====
// Fault checks and limp-mode state update for one sample.
// Depends on lmfs_pkg for the sample, state, result and register types.
`default_nettype none

module lmfs_core import lmfs_pkg::*; (
	input  wire lmfs_cfg_t    cfg,
	input  wire lmfs_state_t  state,
	input  wire lmfs_sample_t sample,
	output lmfs_state_t       state_next,
	output lmfs_result_t      result
);

	logic              f_rev;
	logic              f_heat;
	logic              f_bat;
	logic              entered;
	logic              exited;
	logic              limp_mid;
	logic [TIME_W-1:0] start_mid;
	logic              armed_mid;
	logic [TIME_W-1:0] hold_mid;
	logic [TIME_W-1:0] since_entry;
	logic [TIME_W-1:0] since_arm;
	logic              may_recover;

	always_comb begin
		f_rev  = (sample.engine_rpm >= cfg.fuel_cut_rpm) || (sample.engine_rpm > cfg.max_rpm);
		f_heat = sample.coolant_temp > cfg.coolant_limit;
		f_bat  = (sample.battery_decivolts < cfg.battery_min)
			|| (sample.battery_decivolts > cfg.battery_max);

		// A fault on a sample outside limp mode enters it and stamps the entry time.
		entered   = (f_rev || f_heat || f_bat) && !state.limp_on;
		limp_mid  = state.limp_on || entered;
		start_mid = entered ? sample.now_ms : state.limp_start_ms;

		// An unsafe sample drops any running hold window.
		armed_mid = sample.conditions_safe && state.hold_armed;
		hold_mid  = sample.conditions_safe ? state.hold_start_ms : '0;

		since_entry = sample.now_ms - start_mid;
		since_arm   = sample.now_ms - hold_mid;
		may_recover = sample.recover_request && limp_mid
			&& (since_entry >= {{(TIME_W-16){1'b0}}, cfg.min_limp_ms});

		state_next.limp_on       = limp_mid;
		state_next.limp_start_ms = start_mid;
		state_next.hold_armed    = armed_mid;
		state_next.hold_start_ms = hold_mid;
		exited = 1'b0;

		if (may_recover) begin
			if (!armed_mid) begin
				state_next.hold_armed    = 1'b1;
				state_next.hold_start_ms = sample.now_ms;
			end else if (since_arm >= {{(TIME_W-16){1'b0}}, cfg.recovery_hold_ms}) begin
				state_next = '0;
				exited     = 1'b1;
			end
		end

		result.limp_active    = state_next.limp_on;
		result.over_rev_fault = f_rev;
		result.overheat_fault = f_heat;
		result.battery_fault  = f_bat;
		result.limp_entered   = entered;
		result.recovery_armed = state_next.hold_armed;
		result.limp_exited    = exited;
	end

endmodule

`default_nettype wire

// ===== src/limp_mode_fault_supervisor.sv =====
// Top level of the limp-mode fault supervisor: stream ports, register file,
// sample register, result register. Depends on lmfs_pkg and lmfs_core.
`default_nettype none

// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   one monitoring sample
// m_axis    out        m_axis_tvalid/m_axis_tready   one result per sample
// cfg       in         cfg_valid/cfg_ready           register index and value
//
// Each accepted sample yields exactly one result: it is registered in the
// sample register, then passes through the fault and recovery logic into
// the result register. A new sample can be taken on every cycle while
// m_axis does not stall, so throughput is one sample per clock; the state
// update in lmfs_core is combinational, which is what allows that rate.
// Reset (arst_n low) empties both stages, clears the limp state and loads
// the register defaults. A stall on m_axis holds the result and lets one
// more sample sit in the sample register before s_axis_tready drops.
// The configuration port takes a write on every cycle it is offered one.

module limp_mode_fault_supervisor import lmfs_pkg::*; (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_axis_tvalid,
	output logic                   s_axis_tready,
	// Fields from bit 0 up: now_ms[31:0], engine_rpm[47:32], coolant_temp[63:48],
	// battery_decivolts[79:64], conditions_safe[80], recover_request[81], zero pad.
	input  wire [IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  wire                    m_axis_tready,
	// Fields from bit 0 up: limp_active, over_rev_fault, overheat_fault,
	// battery_fault, limp_entered, recovery_armed, limp_exited, zero pad.
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire [CFG_IDX_W-1:0]    cfg_index,
	input  wire [CFG_DATA_W-1:0]   cfg_data
);

	lmfs_cfg_t    cfg_q;
	lmfs_state_t  state_q;
	lmfs_state_t  state_next;
	lmfs_sample_t sample_s1;
	logic         valid_s1;
	lmfs_result_t result_next;
	lmfs_result_t result_s2;
	logic         valid_s2;
	logic         advance;

	// The register file never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fuel_cut_rpm     <= RST_FUEL_CUT_RPM;
			cfg_q.max_rpm          <= RST_MAX_RPM;
			cfg_q.coolant_limit    <= RST_COOLANT_LIMIT;
			cfg_q.battery_min      <= RST_BATTERY_MIN;
			cfg_q.battery_max      <= RST_BATTERY_MAX;
			cfg_q.min_limp_ms      <= RST_MIN_LIMP_MS;
			cfg_q.recovery_hold_ms <= RST_RECOVERY_HOLD_MS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FUEL_CUT_RPM:     cfg_q.fuel_cut_rpm     <= cfg_data;
				REG_MAX_RPM:          cfg_q.max_rpm          <= cfg_data;
				REG_COOLANT_LIMIT:    cfg_q.coolant_limit    <= cfg_data;
				REG_BATTERY_MIN:      cfg_q.battery_min      <= cfg_data;
				REG_BATTERY_MAX:      cfg_q.battery_max      <= cfg_data;
				REG_MIN_LIMP_MS:      cfg_q.min_limp_ms      <= cfg_data;
				REG_RECOVERY_HOLD_MS: cfg_q.recovery_hold_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	// The sample stage moves on whenever the result register is free or
	// being emptied in this cycle.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_s1 <= lmfs_sample_t'(s_axis_tdata[SAMPLE_W-1:0]);
		end
	end

	lmfs_core u_core (
		.cfg        (cfg_q),
		.state      (state_q),
		.sample     (sample_s1),
		.state_next (state_next),
		.result     (result_next)
	);

	// The limp state only moves when a sample actually passes into the
	// result register, so a stalled output never replays an update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			state_q  <= state_next;
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, result_s2};

endmodule

`default_nettype wire

// ===== src/lmfs_port_checker.sv =====
// Port-level checks on the limp-mode fault supervisor, bound to the top level.
// Depends on lmfs_pkg for the port widths.
`default_nettype none

module lmfs_port_checker import lmfs_pkg::*; (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   m_axis_tvalid,
	input wire                   m_axis_tready,
	input wire [OUT_TDATA_W-1:0] m_axis_tdata
);

	// A stalled result stays offered and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed or was withdrawn");

	// A fresh entry always leaves the block in limp mode.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[0])
		else $error("limp entered but limp not active");

	// Leaving limp mode clears both the mode and the hold window.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[6] |-> !m_axis_tdata[0] && !m_axis_tdata[5])
		else $error("limp exit left mode or hold window set");

	// One sample never both enters and leaves limp mode.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[6]))
		else $error("limp entered and exited on one sample");

endmodule

bind limp_mode_fault_supervisor lmfs_port_checker u_lmfs_port_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for limp_mode_fault_supervisor: a directed table of samples, then
// random monitoring samples over several register settings and idling patterns.
// Depends on lmfs_pkg and the supervisor RTL only; it reads no files.

module tb_top;
	import lmfs_pkg::*;

	// The limit lies far beyond what the slowest correct run needs.
	localparam int unsigned CYCLE_LIMIT      = 400000;
	localparam int unsigned PHASE_COUNT      = 8;
	localparam int unsigned RANDOM_PER_PHASE = 110;
	localparam int unsigned DRAIN_CYCLES     = 6;

	// One row of the directed table. When typed is set, verdict holds the result read
	// straight off the rules; otherwise the predictor supplies the expectation.
	typedef struct packed {
		lmfs_sample_t smp;
		logic         typed;
		lmfs_result_t verdict;
	} table_row_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;

	// Predictor copy of the register file and of the limp-mode tracking state.
	lmfs_cfg_t   limits;
	lmfs_state_t track;

	// Results owed by the block, oldest first.
	lmfs_result_t pending_verdicts[$];
	table_row_t   directed_rows[$];

	// Free-running time base that the random samples advance.
	logic [TIME_W-1:0] sample_clock = '0;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatches     = 0;
	int unsigned cycle_count    = 0;

	// Result field names, indexed by their bit position in m_axis_tdata.
	string field_names[RESULT_W] = '{"limp_active", "over_rev_fault", "overheat_fault",
		"battery_fault", "limp_entered", "recovery_armed", "limp_exited"};

	limp_mode_fault_supervisor DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// Computes the result of one sample and advances the tracked limp state, in the same
	// order as the block: fault checks and entry, then the safe flag, then the request.
	function automatic lmfs_result_t judge_sample(input lmfs_sample_t smp);
		lmfs_result_t      verdict;
		logic [TIME_W-1:0] in_limp_for;
		logic [TIME_W-1:0] armed_for;
		verdict = '0;
		verdict.over_rev_fault = (smp.engine_rpm >= limits.fuel_cut_rpm) ||
			(smp.engine_rpm > limits.max_rpm);
		verdict.overheat_fault = $signed(smp.coolant_temp) > $signed(limits.coolant_limit);
		verdict.battery_fault = (smp.battery_decivolts < limits.battery_min) ||
			(smp.battery_decivolts > limits.battery_max);
		// A fault while already in limp mode leaves the entry time alone.
		if ((verdict.over_rev_fault || verdict.overheat_fault || verdict.battery_fault) &&
				!track.limp_on) begin
			track.limp_on = 1'b1;
			track.limp_start_ms = smp.now_ms;
			verdict.limp_entered = 1'b1;
		end
		// An unsafe sample drops the hold window whether or not limp mode is on.
		if (!smp.conditions_safe) begin
			track.hold_armed = 1'b0;
			track.hold_start_ms = '0;
		end
		// Elapsed times are plain 32-bit differences, so they wrap with the counter.
		in_limp_for = smp.now_ms - track.limp_start_ms;
		armed_for = smp.now_ms - track.hold_start_ms;
		if (smp.recover_request && track.limp_on &&
				in_limp_for >= {16'd0, limits.min_limp_ms}) begin
			if (!track.hold_armed) begin
				track.hold_armed = 1'b1;
				track.hold_start_ms = smp.now_ms;
			end else if (armed_for >= {16'd0, limits.recovery_hold_ms}) begin
				track = '0;
				verdict.limp_exited = 1'b1;
			end
		end
		verdict.limp_active = track.limp_on;
		verdict.recovery_armed = track.hold_armed;
		return verdict;
	endfunction

	function automatic void store_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_FUEL_CUT_RPM:     limits.fuel_cut_rpm = value;
			REG_MAX_RPM:          limits.max_rpm = value;
			REG_COOLANT_LIMIT:    limits.coolant_limit = value;
			REG_BATTERY_MIN:      limits.battery_min = value;
			REG_BATTERY_MAX:      limits.battery_max = value;
			REG_MIN_LIMP_MS:      limits.min_limp_ms = value;
			REG_RECOVERY_HOLD_MS: limits.recovery_hold_ms = value;
			default: ;
		endcase
	endfunction

	function automatic table_row_t table_row(input logic [TIME_W-1:0] now, input int rpm,
			input int temp, input int volt, input bit safe, input bit request,
			input bit typed, input lmfs_result_t verdict);
		table_row_t row;
		row.smp.now_ms = now;
		row.smp.engine_rpm = 16'(rpm);
		row.smp.coolant_temp = 16'(temp);
		row.smp.battery_decivolts = 16'(volt);
		row.smp.conditions_safe = safe;
		row.smp.recover_request = request;
		row.typed = typed;
		row.verdict = verdict;
		return row;
	endfunction

	// A value within three counts of a threshold, on either side of it.
	function automatic logic [15:0] near_threshold(input logic [15:0] thr);
		return thr + 16'($urandom_range(0, 6)) - 16'd3;
	endfunction

	// Builds one random sample. Most samples are healthy; time moves on by small steps or
	// by steps sized to the current limp and hold times, so recovery sequences run to
	// completion. A share has a fault near a threshold; a few are pure noise or time jumps.
	function automatic lmfs_sample_t random_sample();
		lmfs_sample_t smp;
		int unsigned  span;
		int unsigned  pick;
		int           rpm_ceiling;
		int           heat_limit;
		int           bat_lo;
		int           bat_hi;
		smp = '0;
		span = (limits.min_limp_ms > limits.recovery_hold_ms) ?
			limits.min_limp_ms : limits.recovery_hold_ms;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			sample_clock += $urandom_range(0, 20);
		else if (pick < 85)
			sample_clock += $urandom_range(0, 2 * span + 2);
		else if (pick < 96)
			// Land right on, just before or just after one of the two time limits.
			sample_clock += ((pick & 1) ? limits.min_limp_ms : limits.recovery_hold_ms) +
				$urandom_range(0, 2) - 1;
		else
			sample_clock = $urandom();
		smp.now_ms = sample_clock;

		rpm_ceiling = (int'(limits.fuel_cut_rpm) < int'(limits.max_rpm) + 1) ?
			int'(limits.fuel_cut_rpm) : int'(limits.max_rpm) + 1;
		heat_limit = int'($signed(limits.coolant_limit));
		bat_lo = int'(limits.battery_min);
		bat_hi = int'(limits.battery_max);
		smp.engine_rpm = (rpm_ceiling > 0) ? 16'($urandom_range(0, rpm_ceiling - 1)) :
			16'($urandom());
		smp.coolant_temp = 16'(int'($urandom_range(0, heat_limit + 32768)) - 32768);
		smp.battery_decivolts = (bat_lo <= bat_hi) ? 16'($urandom_range(bat_lo, bat_hi)) :
			16'($urandom());

		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			case ($urandom_range(0, 2))
				0: smp.engine_rpm = near_threshold($urandom_range(0, 1) ?
					limits.fuel_cut_rpm : limits.max_rpm);
				1: smp.coolant_temp = near_threshold(limits.coolant_limit);
				default: smp.battery_decivolts = near_threshold($urandom_range(0, 1) ?
					limits.battery_min : limits.battery_max);
			endcase
		end else if (pick < 20) begin
			smp.engine_rpm = 16'($urandom());
			smp.coolant_temp = 16'($urandom());
			smp.battery_decivolts = 16'($urandom());
		end
		smp.conditions_safe = ($urandom_range(0, 99) >= 10);
		smp.recover_request = ($urandom_range(0, 99) < 45);
		return smp;
	endfunction

	// Offers one sample on s_axis and waits for its transfer. tvalid only drops when an
	// idle gap is taken, so back-to-back samples keep it high across the edge.
	task automatic send_sample(input lmfs_sample_t smp, input logic typed,
			input lmfs_result_t typed_verdict);
		lmfs_result_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_TDATA_W'(smp);
		do
			@(posedge clk);
		while (!s_axis_tready);
		// The predictor always runs so its state follows the block, even on typed rows.
		predicted = judge_sample(smp);
		pending_verdicts.push_back(typed ? typed_verdict : predicted);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		store_register(idx, value);
	endtask

	task automatic load_config(input lmfs_cfg_t setting);
		write_register(REG_FUEL_CUT_RPM, setting.fuel_cut_rpm);
		write_register(REG_MAX_RPM, setting.max_rpm);
		write_register(REG_COOLANT_LIMIT, setting.coolant_limit);
		write_register(REG_BATTERY_MIN, setting.battery_min);
		write_register(REG_BATTERY_MAX, setting.battery_max);
		write_register(REG_MIN_LIMP_MS, setting.min_limp_ms);
		write_register(REG_RECOVERY_HOLD_MS, setting.recovery_hold_ms);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_verdict(input lmfs_result_t got);
		lmfs_result_t want;
		if (pending_verdicts.size() == 0) begin
			$error("result 0x%02h transferred with no sample waiting for it", got);
			mismatches++;
		end else begin
			want = pending_verdicts.pop_front();
			for (int i = 0; i < RESULT_W; i++) begin
				if (want[i] !== got[i]) begin
					$error("%s: expected %0b, actual %0b", field_names[i], want[i], got[i]);
					mismatches++;
				end
			end
		end
	endtask

	// Result side: check on every m_axis transfer, then pick the ready level for the next
	// cycle. Values are sampled as they stood before the edge.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_verdict(lmfs_result_t'(m_axis_tdata[RESULT_W-1:0]));
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Watchdog: a block that stops moving data ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		lmfs_cfg_t setting;
		limits = '{RST_FUEL_CUT_RPM, RST_MAX_RPM, RST_COOLANT_LIMIT, RST_BATTERY_MIN,
			RST_BATTERY_MAX, RST_MIN_LIMP_MS, RST_RECOVERY_HOLD_MS};
		track = '0;

		// Directed table, run with the reset register values. The first rows follow reset
		// directly, so their results can be typed in from the rules.
		directed_rows.push_back(table_row(32'd0, 0, 0, 120, 1, 0, 1, 7'b0000000));
		// Speed exactly at the fuel cut enters limp mode.
		directed_rows.push_back(table_row(32'd1, 7000, 0, 120, 1, 0, 1, 7'b0010011));
		// Every field at its top: all three faults, no second entry.
		directed_rows.push_back(table_row(32'd2, 65535, 32767, 65535, 1, 0, 1, 7'b0001111));
		// Every field at its bottom: only the battery is out of its window.
		directed_rows.push_back(table_row(32'd3, 0, -32768, 0, 1, 0, 1, 7'b0001001));
		// A request before the minimum limp time is ignored.
		directed_rows.push_back(table_row(32'd100, 0, 0, 120, 1, 1, 1, 7'b0000001));
		// Request at exactly the minimum limp time arms, a short one waits, unsafe disarms.
		directed_rows.push_back(table_row(32'd5001, 0, 0, 120, 1, 1, 0, '0));
		directed_rows.push_back(table_row(32'd6000, 0, 0, 120, 1, 1, 0, '0));
		directed_rows.push_back(table_row(32'd7000, 0, 0, 120, 0, 0, 0, '0));
		// Rearm, then exit at exactly the hold time.
		directed_rows.push_back(table_row(32'd7001, 0, 0, 120, 1, 1, 0, '0));
		directed_rows.push_back(table_row(32'd9001, 0, 0, 120, 1, 1, 0, '0));
		// Healthy values right at the limits.
		directed_rows.push_back(table_row(32'd9002, 6999, 120, 90, 1, 0, 0, '0));
		// Unsafe sample and a request while out of limp mode.
		directed_rows.push_back(table_row(32'd9003, 0, 0, 160, 0, 1, 0, '0));
		// Fault and request together: the request sees the fresh entry time.
		directed_rows.push_back(table_row(32'd10000, 7500, 0, 120, 1, 1, 0, '0));
		directed_rows.push_back(table_row(32'd10001, 0, 121, 120, 1, 0, 0, '0));
		directed_rows.push_back(table_row(32'd10002, 0, 0, 89, 1, 0, 0, '0));
		directed_rows.push_back(table_row(32'd10003, 0, 0, 161, 1, 0, 0, '0));
		// Arm just below the counter wrap, then exit after it has wrapped.
		directed_rows.push_back(table_row(32'hFFFF_FFF0, 0, 0, 120, 1, 1, 0, '0));
		directed_rows.push_back(table_row(32'h0000_07C0, 0, 0, 120, 1, 1, 0, '0));
		directed_rows.push_back(table_row(32'h0000_07C1, 0, 0, 120, 1, 0, 0, '0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].verdict);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			// Registers only change with the pipeline empty; every sample yields a result,
			// so an empty queue plus a short pause means the block is idle.
			if (p != 0) begin
				s_axis_tvalid <= 1'b0;
				while (pending_verdicts.size() != 0)
					@(posedge clk);
				repeat (4) @(posedge clk);
				case (p)
					2: setting = '{16'd0, 16'd0, -16'sd32768, 16'd0, 16'd0, 16'd0, 16'd0};
					3: setting = '{16'hFFFF, 16'hFFFF, 16'sd32767, 16'd0, 16'hFFFF,
						16'hFFFF, 16'hFFFF};
					// Fuel cut above the rpm ceiling, and a battery window that is empty.
					4: setting = '{16'd9000, 16'd3000, 16'sd95, 16'd200, 16'd50,
						16'd40, 16'd25};
					default: begin
						setting.fuel_cut_rpm = 16'($urandom_range(3000, 9000));
						setting.max_rpm = setting.fuel_cut_rpm + 16'($urandom_range(0, 1500));
						setting.coolant_limit = 16'($urandom_range(60, 140));
						setting.battery_min = 16'($urandom_range(80, 110));
						setting.battery_max = 16'($urandom_range(130, 170));
						setting.min_limp_ms = 16'($urandom_range(0, 3000));
						setting.recovery_hold_ms = 16'($urandom_range(0, 2500));
					end
				endcase
				load_config(setting);
			end
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			repeat (RANDOM_PER_PHASE)
				send_sample(random_sample(), 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;

		// Let the last results out, then give any stray extra result time to show up.
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
